>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SPQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle.
`define SPQ_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Types and constants shared by the sorted priority queue modules.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic [VALUE_W-1:0] NEG_INF_BITS = 64'hFFF0_0000_0000_0000;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      insert;
        logic                      extract;
        logic signed [KEY_W-1:0]   key;
        logic        [VALUE_W-1:0] value;
    } spq_op_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
// One slot of the sorted chain: holds a key and payload, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic                                clk,
    input  wire spq_pkg::spq_op_t                    op,
    input  wire logic                                occ,
    input  wire logic                                left_keep,
    input  wire logic signed [spq_pkg::KEY_W-1:0]    left_key,
    input  wire logic        [spq_pkg::VALUE_W-1:0]  left_value,
    input  wire logic signed [spq_pkg::KEY_W-1:0]    right_key,
    input  wire logic        [spq_pkg::VALUE_W-1:0]  right_value,
    output logic                                     keep,
    output logic signed [spq_pkg::KEY_W-1:0]         key,
    output logic        [spq_pkg::VALUE_W-1:0]       value
);

    logic signed [spq_pkg::KEY_W-1:0]   key_reg,   key_next;
    logic        [spq_pkg::VALUE_W-1:0] value_reg, value_next;

    // Stay in place when this entry sorts at or ahead of the new key.
    assign keep = occ && (key_reg <= op.key);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (op.extract)
        begin
            key_next   = right_key;
            value_next = right_value;
        end
        else if (op.insert && !keep)
        begin
            if (left_keep)
            begin
                key_next   = op.key;
                value_next = op.value;
            end
            else
            begin
                key_next   = left_key;
                value_next = left_value;
            end
        end
        else
        begin
            // Hold the entry.
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue top level: cell chain, entry count and result register.
// Holds up to CAPACITY entries in ascending key order in a chain of cells;
// insert places an entry behind all entries with a smaller or equal key, and
// extract returns the payload of the head entry. All cells compare against
// the new key in parallel and shift in the same edge, so a new item is taken
// each cycle that the result register is empty or being drained. An insert
// on a full queue returns status full and a zero payload; an extract on an
// empty queue returns status empty and the negative-infinity pattern.
// occupancy gives the low 8 bits of the count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               kind,
    input  wire logic signed [spq_pkg::KEY_W-1:0]   item_key,
    input  wire logic        [spq_pkg::VALUE_W-1:0] item_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic             [1:0]                  status,
    output logic             [spq_pkg::VALUE_W-1:0] out_value,
    output logic             [7:0]                  occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         out_valid_reg;
    spq_pkg::status_t             status_reg, status_next;
    logic [spq_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;

    logic                         accept;
    logic                         full;
    logic                         empty;
    spq_pkg::spq_op_t             op;

    logic                                cell_keep  [CAPACITY];
    logic signed [spq_pkg::KEY_W-1:0]    cell_key   [CAPACITY];
    logic        [spq_pkg::VALUE_W-1:0]  cell_value [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign op.insert  = accept && (kind == spq_pkg::KIND_INSERT) && !full;
    assign op.extract = accept && (kind == spq_pkg::KIND_EXTRACT) && !empty;
    assign op.key     = item_key;
    assign op.value   = item_value;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                               occ;
        logic                               left_keep;
        logic signed [spq_pkg::KEY_W-1:0]   left_key;
        logic        [spq_pkg::VALUE_W-1:0] left_value;
        logic signed [spq_pkg::KEY_W-1:0]   right_key;
        logic        [spq_pkg::VALUE_W-1:0] right_value;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            // The head behaves as if a kept entry sat to its left.
            assign left_keep  = 1'b1;
            assign left_key   = cell_key[i];
            assign left_value = cell_value[i];
        end
        else
        begin : g_body
            assign left_keep  = cell_keep[i-1];
            assign left_key   = cell_key[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key   = cell_key[i];
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_key   = cell_key[i+1];
            assign right_value = cell_value[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .op          (op),
            .occ         (occ),
            .left_keep   (left_keep),
            .left_key    (left_key),
            .left_value  (left_value),
            .right_key   (right_key),
            .right_value (right_value),
            .keep        (cell_keep[i]),
            .key         (cell_key[i]),
            .value       (cell_value[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.extract)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        status_next    = spq_pkg::ST_OK;
        out_value_next = '0;
        if (kind == spq_pkg::KIND_INSERT)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
        end
        else if (empty)
        begin
            status_next    = spq_pkg::ST_EMPTY;
            out_value_next = spq_pkg::NEG_INF_BITS;
        end
        else
        begin
            out_value_next = cell_value[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign occupancy = 8'(count_reg);

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SPQ_ASSERT_NEXT(a_insert_grows, op.insert, count_reg == $past(count_reg) + 1'b1, "insert did not grow count")
    `SPQ_ASSERT(a_head_sorted, (count_reg < CNT_W'(2)) || (cell_key[0] <= cell_key[1]), "head entries out of order")
    `SPQ_ASSERT(a_full_status, !(out_valid_reg && status_reg == spq_pkg::ST_FULL) || full, "full status with room left")

endmodule

`default_nettype wire
